// ===== rtl/core/shortcut_3x1_stopping_time_memo_macros.svh =====
// Assertion helpers shared by the core; clk and rst_n are taken from the using scope.
`ifndef SHORTCUT_3X1_STOPPING_TIME_MEMO_MACROS_SVH
`define SHORTCUT_3X1_STOPPING_TIME_MEMO_MACROS_SVH

// Same-cycle implication.
`define SCST_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SCST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/scst_pkg.sv =====
package scst_pkg;

    localparam int LIMIT_W = 20;
    localparam int START_W = 32;
    localparam int COUNT_W = 16;
    localparam int SUM_W   = COUNT_W + 1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'hFFFFF;
    localparam logic [COUNT_W-1:0] MARK_OVER   = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFE;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_WALK = 5'b00010,
        S_HIT  = 5'b00100,
        S_FILL = 5'b01000,
        S_DONE = 5'b10000
    } scst_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } scst_traj_cmd_t;

    typedef struct packed {
        logic upper_zero;
        logic is_one;
        logic odd;
        logic wide_fail;
    } scst_traj_stat_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } scst_path_cmd_t;

endpackage

// ===== rtl/core/scst_traj.sv =====
module scst_traj #(
    parameter int VB = 128,
    parameter int AW = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  scst_pkg::scst_traj_cmd_t     cmd,
    input  logic [scst_pkg::START_W-1:0] start_value,
    output logic [AW-1:0]                lo,
    output scst_pkg::scst_traj_stat_t    stat
);
    import scst_pkg::*;

    logic [VB-1:0] traj_reg;
    logic [VB-1:0] traj_next;
    logic [VB-1:0] half;
    logic [VB:0]   odd_sum;

    // (3v+1)/2 for odd v is v + (v >> 1) + 1
    assign half    = traj_reg >> 1;
    assign odd_sum = {1'b0, traj_reg} + {1'b0, half} + (VB + 1)'(1);

    assign lo              = traj_reg[AW-1:0];
    assign stat.upper_zero = (traj_reg[VB-1:AW] == '0);
    assign stat.is_one     = (traj_reg == VB'(1));
    assign stat.odd        = traj_reg[0];
    assign stat.wide_fail  = odd_sum[VB];

    always_comb
    begin
        traj_next = traj_reg;
        if (cmd.load)
        begin
            traj_next = VB'(start_value);
        end
        else if (cmd.step)
        begin
            traj_next = traj_reg[0] ? odd_sum[VB-1:0] : half;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            traj_reg <= '0;
        end
        else
        begin
            traj_reg <= traj_next;
        end
    end

endmodule

// ===== rtl/core/scst_path.sv =====
module scst_path #(
    parameter int DEPTH = 4096,
    parameter int DW    = 20,
    parameter int CW    = 13
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  scst_pkg::scst_path_cmd_t cmd,
    input  logic [DW-1:0]            push_data,
    output logic [CW-1:0]            top,
    output logic                     full,
    output logic                     pop_valid,
    output logic [DW-1:0]            pop_data
);
    import scst_pkg::*;

    localparam int SW = $clog2(DEPTH);

    logic [DW-1:0] mem [DEPTH];
    logic [CW-1:0] top_reg;
    logic [CW-1:0] top_next;
    logic [CW-1:0] pop_idx;
    logic          pop_valid_reg;
    logic [DW-1:0] pop_data_reg;

    assign pop_idx   = top_reg - CW'(1);
    assign top       = top_reg;
    assign full      = (top_reg == CW'(DEPTH));
    assign pop_valid = pop_valid_reg;
    assign pop_data  = pop_data_reg;

    always_comb
    begin
        top_next = top_reg;
        if (cmd.clear)
        begin
            top_next = '0;
        end
        else if (cmd.push)
        begin
            top_next = top_reg + CW'(1);
        end
        else if (cmd.pop)
        begin
            top_next = pop_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg       <= '0;
            pop_valid_reg <= 1'b0;
        end
        else
        begin
            top_reg       <= top_next;
            pop_valid_reg <= cmd.pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[top_reg[SW-1:0]] <= push_data;
        end
        if (cmd.pop)
        begin
            pop_data_reg <= mem[pop_idx[SW-1:0]];
        end
    end

endmodule

// ===== rtl/core/scst_memo.sv =====
module scst_memo #(
    parameter int ENTRIES = 1048576,
    parameter int AW      = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,
    output logic                         clear_busy,
    input  logic                         ren,
    input  logic [AW-1:0]                raddr,
    output logic [scst_pkg::COUNT_W-1:0] rdata,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [scst_pkg::COUNT_W-1:0] wdata
);
    import scst_pkg::*;

    logic [COUNT_W-1:0] mem [ENTRIES];
    logic [COUNT_W-1:0] rdata_reg;
    logic               clr_busy_reg;
    logic               clr_busy_next;
    logic [AW-1:0]      clr_addr_reg;
    logic [AW-1:0]      clr_addr_next;

    assign clear_busy = clr_busy_reg;
    assign rdata      = rdata_reg;

    // zero sweep after reset, one entry per cycle
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(ENTRIES - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/shortcut_3x1_stopping_time_memo.sv =====
// Shortcut 3x+1 stopping time with a memo table. Each accepted start value walks its
// trajectory one step per cycle while the value is above the effective memo limit, and at
// or below it each step waits for a memo read (S_WALK, then S_HIT), then writes the path
// back into the memo table at one entry per cycle. The path stack depth bounds the path.
// The memo table is a single synchronous RAM, and after reset it is swept to zero, during
// which no start value is taken (register writes are).
`include "shortcut_3x1_stopping_time_memo_macros.svh"

module shortcut_3x1_stopping_time_memo #(
    parameter int TABLE_ENTRIES = 1048576,
    parameter int PATH_DEPTH    = 4096,
    parameter int VALUE_BITS    = 128
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [scst_pkg::LIMIT_W-1:0] cfg_wr_data,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic [scst_pkg::START_W-1:0] start_value,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [scst_pkg::COUNT_W-1:0] step_count,
    output logic                         overflow
);
    import scst_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(PATH_DEPTH + 1);
    localparam int LW = (AW > LIMIT_W) ? AW : LIMIT_W;
    localparam logic [LW-1:0] TOP_IDX = LW'(TABLE_ENTRIES - 1);

    scst_state_t        state_reg;
    scst_state_t        state_next;
    logic [LIMIT_W-1:0] memo_limit_reg;
    logic [COUNT_W-1:0] base_reg;
    logic [COUNT_W-1:0] base_next;
    logic [CW-1:0]      dist_reg;
    logic [CW-1:0]      dist_next;
    logic               result_valid_reg;
    logic               result_valid_next;
    logic [COUNT_W-1:0] step_count_reg;
    logic               overflow_reg;

    scst_traj_cmd_t     traj_cmd;
    scst_traj_stat_t    traj_stat;
    logic [AW-1:0]      traj_lo;

    scst_path_cmd_t     path_cmd;
    logic [AW-1:0]      push_data;
    logic [CW-1:0]      path_top;
    logic               path_full;
    logic               pop_valid;
    logic [AW-1:0]      pop_data;

    logic               clear_busy;
    logic               memo_ren;
    logic [COUNT_W-1:0] memo_rdata;
    logic               memo_we;
    logic [COUNT_W-1:0] fill_value;

    logic [LW-1:0]      lim_wide;
    logic [AW-1:0]      lim_eff;
    logic               in_memo;
    logic               do_adv;
    logic               res_load;
    logic [SUM_W-1:0]   fill_sum;
    logic [SUM_W-1:0]   total_sum;
    logic               total_over;

    scst_traj #(
        .VB (VALUE_BITS),
        .AW (AW)
    ) u_traj (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (traj_cmd),
        .start_value (start_value),
        .lo          (traj_lo),
        .stat        (traj_stat)
    );

    scst_path #(
        .DEPTH (PATH_DEPTH),
        .DW    (AW),
        .CW    (CW)
    ) u_path (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (path_cmd),
        .push_data (push_data),
        .top       (path_top),
        .full      (path_full),
        .pop_valid (pop_valid),
        .pop_data  (pop_data)
    );

    scst_memo #(
        .ENTRIES (TABLE_ENTRIES),
        .AW      (AW)
    ) u_memo (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear_busy (clear_busy),
        .ren        (memo_ren),
        .raddr      (traj_lo),
        .rdata      (memo_rdata),
        .we         (memo_we),
        .waddr      (pop_data),
        .wdata      (fill_value)
    );

    assign lim_wide = LW'(memo_limit_reg);
    assign lim_eff  = (lim_wide > TOP_IDX) ? TOP_IDX[AW-1:0] : lim_wide[AW-1:0];
    assign in_memo  = traj_stat.upper_zero && (traj_lo <= lim_eff);
    assign push_data = in_memo ? traj_lo : '0;

    // backfill: popped entries arrive deepest-first, distance counts up from 1
    assign fill_sum   = SUM_W'(base_reg) + SUM_W'(dist_reg) + SUM_W'(1);
    assign fill_value = ((base_reg == MARK_OVER) || (fill_sum > SUM_W'(COUNT_MAX)))
                        ? MARK_OVER : fill_sum[COUNT_W-1:0];
    // marker 0 stands for a value above the limit, or for zero itself
    assign memo_we    = pop_valid && (pop_data != '0);

    assign total_sum  = SUM_W'(base_reg) + SUM_W'(dist_reg);
    assign total_over = (base_reg == MARK_OVER) || (total_sum > SUM_W'(COUNT_MAX));

    assign item_stall   = (state_reg != S_IDLE) || clear_busy;
    assign result_valid = result_valid_reg;
    assign step_count   = step_count_reg;
    assign overflow     = overflow_reg;

    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        dist_next  = pop_valid ? (dist_reg + CW'(1)) : dist_reg;
        traj_cmd   = '0;
        path_cmd   = '0;
        memo_ren   = 1'b0;
        do_adv     = 1'b0;
        res_load   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid && !item_stall)
                begin
                    traj_cmd.load  = 1'b1;
                    path_cmd.clear = 1'b1;
                    dist_next      = '0;
                    state_next     = S_WALK;
                end
            end
            S_WALK:
            begin
                if (in_memo)
                begin
                    memo_ren   = 1'b1;
                    state_next = S_HIT;
                end
                else
                begin
                    do_adv = 1'b1;
                end
            end
            S_HIT:
            begin
                if (memo_rdata != '0)
                begin
                    base_next  = memo_rdata;
                    state_next = S_FILL;
                end
                else
                begin
                    do_adv = 1'b1;
                end
            end
            S_FILL:
            begin
                if (path_top != '0)
                begin
                    path_cmd.pop = 1'b1;
                end
                else if (!pop_valid)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_adv)
        begin
            if (traj_stat.is_one)
            begin
                base_next  = '0;
                state_next = S_FILL;
            end
            else if (path_full)
            begin
                base_next  = MARK_OVER;
                state_next = S_FILL;
            end
            else
            begin
                path_cmd.push = 1'b1;
                if (traj_stat.odd && traj_stat.wide_fail)
                begin
                    base_next  = MARK_OVER;
                    state_next = S_FILL;
                end
                else
                begin
                    traj_cmd.step = 1'b1;
                    state_next    = S_WALK;
                end
            end
        end
    end

    assign result_valid_next = res_load || (result_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            memo_limit_reg   <= LIMIT_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            if (cfg_wr_en)
            begin
                memo_limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        dist_reg <= dist_next;
        if (res_load)
        begin
            overflow_reg   <= total_over;
            step_count_reg <= total_over ? MARK_OVER : total_sum[COUNT_W-1:0];
        end
    end

    `SCST_ASSERT_SAME(a_fill_no_marker, memo_we, pop_data != '0, "backfill wrote entry zero")
    `SCST_ASSERT_SAME(a_over_mark, result_valid, !overflow || step_count == MARK_OVER,
                      "overflow result without saturated count")
    `SCST_ASSERT_SAME(a_path_bound, 1'b1, path_top <= CW'(PATH_DEPTH), "path stack overrun")
    `SCST_ASSERT_NEXT(a_lookup_next, state_reg == S_WALK && memo_ren, state_reg == S_HIT,
                      "memo lookup not followed by hit check")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import scst_pkg::*;

    localparam int TABLE_ENTRIES  = 1048576;
    localparam int PATH_DEPTH     = 4096;
    localparam int VALUE_BITS     = 128;
    // the memo clear after reset alone sweeps all TABLE_ENTRIES entries with no traffic
    localparam int WATCHDOG_LIMIT = 3000000;
    localparam int SETTLE_CYCLES  = 16;

    typedef struct packed {
        logic [COUNT_W-1:0] steps;
        logic               ovf;
    } stop_time_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_wr_en    = 1'b0;
    logic [LIMIT_W-1:0] cfg_wr_data  = '0;
    logic               item_valid   = 1'b0;
    logic               item_stall;
    logic [START_W-1:0] start_value  = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic [COUNT_W-1:0] step_count;
    logic               overflow;

    bit [COUNT_W-1:0]   memo_model [TABLE_ENTRIES];
    bit [LIMIT_W-1:0]   path_model [PATH_DEPTH];
    logic [LIMIT_W-1:0] limit_model = LIMIT_RESET;

    logic [START_W-1:0] pending_starts [$];
    stop_time_t         expected_times [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count   = 0;
    int quiet_cycles  = 0;

    shortcut_3x1_stopping_time_memo #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PATH_DEPTH    (PATH_DEPTH),
        .VALUE_BITS    (VALUE_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .start_value  (start_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .step_count   (step_count),
        .overflow     (overflow)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Walks the trajectory, then backfills the memo copy along the path.
    function automatic stop_time_t predict_stop_time(input logic [START_W-1:0] start);
        logic [VALUE_BITS-1:0] v;
        logic [VALUE_BITS:0]   sum;
        logic [63:0]           lo;
        logic [LIMIT_W-1:0]    lim;
        logic [LIMIT_W-1:0]    idx;
        int unsigned           base;
        int unsigned           depth;
        int unsigned           run_total;
        int unsigned           i;
        logic                  fits;
        logic                  in_memo;
        logic                  done;
        stop_time_t            res;

        lim   = (limit_model > TABLE_ENTRIES - 1) ? LIMIT_W'(TABLE_ENTRIES - 1) : limit_model;
        v     = VALUE_BITS'(start);
        depth = 0;
        base  = 0;
        done  = 1'b0;
        while (!done) begin
            fits    = (v[VALUE_BITS-1:64] == '0);
            lo      = v[63:0];
            in_memo = fits && (lo <= 64'(lim));
            if (in_memo && memo_model[lo[LIMIT_W-1:0]] != 0) begin
                base = memo_model[lo[LIMIT_W-1:0]];
                done = 1'b1;
            end else if (fits && lo == 64'd1) begin
                base = 0;
                done = 1'b1;
            end else if (depth >= PATH_DEPTH) begin
                base = MARK_OVER;
                done = 1'b1;
            end else begin
                // values above the limit go on the path as marker 0
                path_model[depth] = in_memo ? lo[LIMIT_W-1:0] : '0;
                depth++;
                if (v[0]) begin
                    sum = {1'b0, v} + {2'b0, v[VALUE_BITS-1:1]} + 1'b1;
                    if (sum[VALUE_BITS]) begin
                        base = MARK_OVER;
                        done = 1'b1;
                    end else begin
                        v = sum[VALUE_BITS-1:0];
                    end
                end else begin
                    v = v >> 1;
                end
            end
        end

        for (i = depth; i > 0; i--) begin
            idx       = path_model[i-1];
            run_total = base + (depth - (i - 1));
            if (idx != 0 && memo_model[idx] == 0)
                memo_model[idx] = (base == MARK_OVER || run_total > COUNT_MAX)
                                  ? MARK_OVER : run_total[COUNT_W-1:0];
        end

        if (base == MARK_OVER || base + depth > COUNT_MAX) begin
            res.steps = MARK_OVER;
            res.ovf   = 1'b1;
        end else begin
            res.steps = COUNT_W'(base + depth);
            res.ovf   = 1'b0;
        end
        return res;
    endfunction

    // Start value driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            item_valid  <= 1'b0;
            start_value <= '0;
        end else begin
            if (item_valid && !item_stall)
                expected_times.push_back(predict_stop_time(start_value));
            if (!item_valid || !item_stall) begin
                if (pending_starts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    item_valid  <= 1'b1;
                    start_value <= pending_starts.pop_front();
                end else begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge clk or negedge rst_n) begin
        stop_time_t want;
        if (!rst_n) begin
            result_stall <= 1'b0;
        end else begin
            if (result_valid && !result_stall) begin
                if (expected_times.size() == 0) begin
                    error_count++;
                    $error("result beat with nothing pending: step_count %0d overflow %0d",
                           step_count, overflow);
                end else begin
                    want = expected_times.pop_front();
                    if (step_count !== want.steps) begin
                        error_count++;
                        $error("step_count: expected %0d, actual %0d", want.steps, step_count);
                    end
                    if (overflow !== want.ovf) begin
                        error_count++;
                        $error("overflow: expected %0d, actual %0d", want.ovf, overflow);
                    end
                end
            end
            result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic drain_and_settle();
        while (pending_starts.size() != 0 || item_valid || expected_times.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_memo_limit(input logic [LIMIT_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        limit_model = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_random_starts(input int count);
        int                 k;
        int                 r;
        logic [START_W-1:0] s;
        for (k = 0; k < count; k++) begin
            r = $urandom_range(999);
            if (r < 2)
                s = '0;   // zero walks the full path depth, keep it rare
            else if (r < 300)
                s = $urandom_range(5000, 1);
            else if (r < 450)
                s = START_W'(limit_model) + $urandom_range(20) - 10;
            else
                s = $urandom();
            pending_starts.push_back(s);
        end
    endtask

    initial begin
        logic [START_W-1:0] directed_starts [] = '{
            32'd1, 32'd2, 32'd3, 32'd27, 32'd0, 32'hFFFF_FFFF, 32'h8000_0000,
            32'd1048575, 32'd1048576, 32'd1048577, 32'hAAAA_AAAA, 32'h5555_5555,
            32'd7, 32'd27, 32'd97, 32'd871, 32'd6171, 32'd1, 32'h7FFF_FFFF,
            32'd837799, 32'd2
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        write_memo_limit(LIMIT_RESET);
        send_idle_pct = 16;
        recv_idle_pct = 50;
        foreach (directed_starts[k])
            pending_starts.push_back(directed_starts[k]);
        queue_random_starts(300);

        drain_and_settle();
        write_memo_limit(20'd1);
        queue_random_starts(330);

        drain_and_settle();
        write_memo_limit(LIMIT_W'($urandom_range(1048575, 1)));
        send_idle_pct = 50;
        recv_idle_pct = 16;
        queue_random_starts(330);

        drain_and_settle();
        write_memo_limit(20'd1000);
        queue_random_starts(330);

        drain_and_settle();
        write_memo_limit(20'd65536);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_starts(330);

        drain_and_settle();
        write_memo_limit(LIMIT_W'($urandom_range(1048575, 1)));
        queue_random_starts(330);

        drain_and_settle();
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
